/* rtl/hslm_pkg.sv */
// Shared types, codes and hash helpers for the hashed source location map.
package hslm_pkg;

  // Multipliers of the xorshift-multiply key hash
  localparam logic [31:0] HASH_MUL_A = 32'h7feb352d;
  localparam logic [31:0] HASH_MUL_B = 32'h846ca68b;

  // Item command codes
  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_GET = 1'b1
  } cmd_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    item_load;    // capture the input beat
    logic    probe_start;  // read the slot at the hash start
    logic    probe_next;   // step to the next slot
    logic    clear_wr;     // mark the current slot empty
    logic    insert;       // append entry, claim current empty slot
    logic    update;       // overwrite the hit entry
    logic    fetch;        // read the hit entry
    logic    res_set;      // latch the result status
    status_e res_status;
    logic    out_load;     // move the result into the output register
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic ref_zero;    // slot just read is empty
    logic key_match;   // slot key equals the item key
    logic probe_last;  // every slot has been visited
    logic addr_last;   // slot address at the top of the table
    logic full;        // load rule refuses a new key
    logic is_get;      // item is a lookup
    logic out_free;    // output register can take a result
  } sts_t;

  // x ^ (x >> 16)
  function automatic logic [31:0] mix_fold16(input logic [31:0] x);
    mix_fold16 = x ^ (x >> 16);
  endfunction

  // x ^ (x >> 15)
  function automatic logic [31:0] mix_fold15(input logic [31:0] x);
    mix_fold15 = x ^ (x >> 15);
  endfunction

endpackage

/* rtl/hslm_dp.sv */
// Datapath of the hashed source location map: hash, slot and entry memories, result.
module hslm_dp #(
  parameter int TABLE_SLOTS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hslm_pkg::ctl_t     ctl_i,
  output hslm_pkg::sts_t     sts_o,
  input  logic               cmd_i,
  input  logic        [31:0] key_i,
  input  logic signed [31:0] line_i,
  input  logic signed [31:0] column_i,
  input  logic        [31:0] file_handle_i,
  input  logic        [31:0] text_handle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [2:0]  status_o,
  output logic signed [31:0] found_line_o,
  output logic signed [31:0] found_column_o,
  output logic        [31:0] found_file_o,
  output logic        [31:0] found_text_o,
  output logic        [7:0]  entry_number_o
);

  localparam int IW    = $clog2(TABLE_SLOTS);
  localparam int LIMIT = (TABLE_SLOTS * 7 + 9) / 10;

  typedef struct packed {
    logic [31:0]   key;
    logic [IW-1:0] slot_ref;
  } slot_t;

  typedef struct packed {
    logic [31:0] line;
    logic [31:0] column;
    logic [31:0] file;
    logic [31:0] text;
  } entry_t;

  // Item registers
  hslm_pkg::cmd_e cmd_q;
  logic [31:0]    key_q;
  entry_t         item_q;

  // Hash pipeline
  logic [31:0] mul1_d, mul1_q, mul2_d, mul2_q, hash_w;

  // Probe state
  logic [IW-1:0] slot_addr_q, rd_addr, probe_cnt_q, hit_idx, ins_ref;
  slot_t         slot_rd_q, slot_wdata;
  logic          slot_we;

  // Entry state
  entry_t            ent_mem [TABLE_SLOTS];
  slot_t             slot_mem [TABLE_SLOTS];
  entry_t            ent_rd_q;
  logic [IW-1:0]     ent_q, ent_waddr, entry_count_q;
  logic              ent_we;
  hslm_pkg::status_e res_status_q;
  logic              full;

  // Output register
  logic              out_valid_q;
  hslm_pkg::status_e out_status_q;
  entry_t            out_data_q;
  logic [7:0]        out_num_q;

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (ctl_i.item_load) begin
      cmd_q  <= hslm_pkg::cmd_e'(cmd_i);
      key_q  <= key_i;
      item_q <= '{line: line_i, column: column_i, file: file_handle_i, text: text_handle_i};
    end
  end

  // Two-stage hash, one multiply per stage
  assign mul1_d = hslm_pkg::mix_fold16(key_q) * hslm_pkg::HASH_MUL_A;
  assign mul2_d = hslm_pkg::mix_fold15(mul1_q) * hslm_pkg::HASH_MUL_B;
  assign hash_w = hslm_pkg::mix_fold16(mul2_q);

  always_ff @(posedge clk_i) begin
    mul1_q <= mul1_d;
    mul2_q <= mul2_d;
  end

  // Slot read address
  always_comb begin
    if (ctl_i.probe_start) begin
      rd_addr = hash_w[IW-1:0];
    end else if (ctl_i.probe_next) begin
      rd_addr = IW'(slot_addr_q + 1'b1);
    end else begin
      rd_addr = slot_addr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_addr_q <= '0;
      probe_cnt_q <= '0;
    end else begin
      slot_addr_q <= rd_addr;
      if (ctl_i.probe_start) begin
        probe_cnt_q <= '0;
      end else if (ctl_i.probe_next) begin
        probe_cnt_q <= IW'(probe_cnt_q + 1'b1);
      end
    end
  end

  // Slot memory: clear pass or claim of an empty slot
  assign ins_ref    = IW'(entry_count_q + 1'b1);
  assign slot_we    = ctl_i.clear_wr | (ctl_i.insert & sts_o.ref_zero);
  assign slot_wdata = ctl_i.clear_wr ? slot_t'('0) : slot_t'{key: key_q, slot_ref: ins_ref};

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_addr_q] <= slot_wdata;
    end
    slot_rd_q <= slot_mem[rd_addr];
  end

  // Entry memory
  assign hit_idx   = IW'(slot_rd_q.slot_ref - 1'b1);
  assign ent_we    = ctl_i.insert | ctl_i.update;
  assign ent_waddr = ctl_i.insert ? entry_count_q : hit_idx;

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= item_q;
    end
    if (ctl_i.fetch) begin
      ent_rd_q <= ent_mem[hit_idx];
    end
  end

  // Result bookkeeping
  always_ff @(posedge clk_i) begin
    if (ctl_i.insert) begin
      ent_q <= entry_count_q;
    end else if (ctl_i.update || ctl_i.fetch) begin
      ent_q <= hit_idx;
    end
    if (ctl_i.res_set) begin
      res_status_q <= ctl_i.res_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (ctl_i.insert) begin
      entry_count_q <= IW'(entry_count_q + 1'b1);
    end
  end

  // Load rule: (count + 1) * 10 >= slots * 7
  assign full = ({1'b0, entry_count_q} + 1'b1) >= (IW+1)'(LIMIT);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_status_q <= res_status_q;
      out_data_q   <= (res_status_q == hslm_pkg::ST_FOUND) ? ent_rd_q : entry_t'('0);
      if (res_status_q inside {hslm_pkg::ST_NOT_FOUND, hslm_pkg::ST_FULL}) begin
        out_num_q <= '0;
      end else begin
        out_num_q <= 8'(ent_q);
      end
    end
  end

  // Status to the controller
  assign sts_o.ref_zero   = (slot_rd_q.slot_ref == '0);
  assign sts_o.key_match  = (slot_rd_q.key == key_q);
  assign sts_o.probe_last = &probe_cnt_q;
  assign sts_o.addr_last  = &slot_addr_q;
  assign sts_o.full       = full;
  assign sts_o.is_get     = (cmd_q == hslm_pkg::CMD_GET);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign found_line_o   = out_data_q.line;
  assign found_column_o = out_data_q.column;
  assign found_file_o   = out_data_q.file;
  assign found_text_o   = out_data_q.text;
  assign entry_number_o = out_num_q;

endmodule

/* rtl/hslm_ctrl.sv */
// Controller of the hashed source location map: clear pass, hash wait, probe walk.
module hslm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hslm_pkg::sts_t sts_i,
  output hslm_pkg::ctl_t ctl_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH1,
    S_HASH2,
    S_START,
    S_PROBE,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    ctl_o.res_status = hslm_pkg::ST_NOT_FOUND;
    case (state_q)
      S_CLEAR: begin
        ctl_o.clear_wr   = 1'b1;
        ctl_o.probe_next = 1'b1;
        if (sts_i.addr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ctl_o.item_load = in_valid_i & rdy_q;
        if (in_valid_i && rdy_q) begin
          state_d = S_HASH1;
        end
      end
      S_HASH1: state_d = S_HASH2;
      S_HASH2: state_d = S_START;
      S_START: begin
        ctl_o.probe_start = 1'b1;
        state_d = S_PROBE;
      end
      S_PROBE: begin
        if (sts_i.ref_zero || (!sts_i.key_match && sts_i.probe_last)) begin
          // key absent
          ctl_o.res_set = 1'b1;
          state_d = S_DONE;
          if (sts_i.is_get) begin
            ctl_o.res_status = hslm_pkg::ST_NOT_FOUND;
          end else if (sts_i.full) begin
            ctl_o.res_status = hslm_pkg::ST_FULL;
          end else begin
            ctl_o.insert     = 1'b1;
            ctl_o.res_status = hslm_pkg::ST_INSERTED;
          end
        end else if (sts_i.key_match) begin
          // key present
          ctl_o.res_set = 1'b1;
          state_d = S_DONE;
          if (sts_i.is_get) begin
            ctl_o.fetch      = 1'b1;
            ctl_o.res_status = hslm_pkg::ST_FOUND;
          end else begin
            ctl_o.update     = 1'b1;
            ctl_o.res_status = hslm_pkg::ST_UPDATED;
          end
        end else begin
          ctl_o.probe_next = 1'b1;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      rdy_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rdy_q   <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = rdy_q;

endmodule

/* rtl/hashed_source_location_map.sv */
// Top level of the hashed source location map.
//
// Input channel (in_valid_i / in_ready_o) carries one command beat: an add
// (cmd 0) stores line, column and the two handles under key; a get (cmd 1)
// looks the key up. Output channel (out_valid_o / out_ready_i) returns one
// result beat per command: status, the stored fields for a found key, and
// the entry number.
// One item at a time: accept, the hash multiply states S_HASH1 and S_HASH2,
// S_START to start the probe, then the probe walk of the slot memory (one
// slot per cycle, linear probing), then S_DONE to load the output register.
// The next item is accepted only after the result of the last one is loaded.
// The single-port slot memory read sets the probe rate.
// After reset the slot table is swept empty, one slot per cycle, and in_ready_o
// stays low until the sweep ends.
// A stalled receiver holds the result in the output register; a new beat
// is still accepted and processed, and waits only to load its own result.
// A new key is refused with a full status once the load limit is reached.
module hashed_source_location_map #(
  parameter int TABLE_SLOTS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic        [31:0] key_i,
  input  logic signed [31:0] line_i,
  input  logic signed [31:0] column_i,
  input  logic        [31:0] file_handle_i,
  input  logic        [31:0] text_handle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [2:0]  status_o,
  output logic signed [31:0] found_line_o,
  output logic signed [31:0] found_column_o,
  output logic        [31:0] found_file_o,
  output logic        [31:0] found_text_o,
  output logic        [7:0]  entry_number_o
);

  hslm_pkg::ctl_t ctl;
  hslm_pkg::sts_t sts;

  hslm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  hslm_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .cmd_i          (cmd_i),
    .key_i          (key_i),
    .line_i         (line_i),
    .column_i       (column_i),
    .file_handle_i  (file_handle_i),
    .text_handle_i  (text_handle_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .found_line_o   (found_line_o),
    .found_column_o (found_column_o),
    .found_file_o   (found_file_o),
    .found_text_o   (found_text_o),
    .entry_number_o (entry_number_o)
  );

endmodule

/* rtl/hslm_checker.sv */
// Port-level checks for the hashed source location map, bound to the top level.
module hslm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic        [2:0]  status_o,
  input logic signed [31:0] found_line_o,
  input logic signed [31:0] found_column_o,
  input logic        [31:0] found_file_o,
  input logic        [31:0] found_text_o,
  input logic        [7:0]  entry_number_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(entry_number_o) && $stable(found_line_o))
    else $error("result beat changed while stalled");

  // Hash and probe start keep the block busy after an accepted beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("input ready during hash of previous beat");

  // Miss and refusal carry no entry number
  a_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == hslm_pkg::ST_NOT_FOUND || status_o == hslm_pkg::ST_FULL)
      |-> entry_number_o == 8'd0)
    else $error("entry number on miss or refusal");

  // Only a found result carries stored fields
  a_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != hslm_pkg::ST_FOUND
      |-> found_line_o == 32'sd0 && found_column_o == 32'sd0
        && found_file_o == 32'd0 && found_text_o == 32'd0)
    else $error("stored fields on a result that is not found");

endmodule

bind hashed_source_location_map hslm_checker u_hslm_checker (.*);
